// ===== hw/rtl/mrmf_pkg.sv =====
// ----------------------------------------------------------------------------
// mrmf_pkg
// Shared types and constants of the masked region minimizer filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mrmf_pkg;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int POS_W   = 31;
    localparam int WORD_W  = 64;
    localparam int SPAN_W  = 8;
    localparam int HALF_W  = SPAN_W - 1;
    // Signed window coordinate and signed overlap term
    localparam int COORD_W = POS_W + 2;
    localparam int TERM_W  = COORD_W + 1;

    localparam int DEF_MAX_INTERVALS = 1024;

    localparam logic [SPAN_W-1:0] SPAN_MASK = 8'hff;

    // Input word kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MZ    = 2'd2;

    // One stored interval
    typedef struct packed {
        logic [POS_W-1:0] iv_start;
        logic [POS_W-1:0] iv_end;
    } t_entry;

    // Compare results of the overlap unit
    typedef struct packed {
        logic end_le_s;
        logic start_lt_e;
    } t_flags;

endpackage

`default_nettype wire

// ===== hw/rtl/masked_region_minimizer_filter.sv =====
// ----------------------------------------------------------------------------
// masked_region_minimizer_filter
// Drops minimizers that lie mostly inside masked low-complexity intervals.
// ----------------------------------------------------------------------------
// Usage: present a word on i_kind and the payload ports with start high; it
// is taken at a rising edge where start is high and busy is low.
// A clear word empties the interval store, a load word appends one interval
// (ignored once the store holds MAX_INTERVALS), a minimizer word is checked
// against the intervals from the scan pointer onward.
// Clear and load words leave busy low.
// A minimizer word keeps busy high while it walks the intervals it skips
// and those it overlaps: the single read port of the interval memory
// delivers one entry per cycle to the shared overlap unit.
// A kept minimizer appears on o_kept_key / o_kept_pos with o_kept_valid high
// for one cycle, the cycle in which busy falls; a dropped one gives no word.
// The receiver cannot stall; every strobed word is final.
// Reset clears the interval count, the scan pointer and the sequencer; the
// store contents are left as they are and need no clearing pass, since only
// entries below the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_region_minimizer_filter #(
    parameter int MAX_INTERVALS = mrmf_pkg::DEF_MAX_INTERVALS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire [mrmf_pkg::KIND_W-1:0]       i_kind,
    input  wire [mrmf_pkg::POS_W-1:0]        i_interval_start,
    input  wire [mrmf_pkg::POS_W-1:0]        i_interval_end,
    input  wire [mrmf_pkg::WORD_W-1:0]       i_mz_key,
    input  wire [mrmf_pkg::WORD_W-1:0]       i_mz_pos,
    output logic                             o_kept_valid,
    output logic [mrmf_pkg::WORD_W-1:0]      o_kept_key,
    output logic [mrmf_pkg::WORD_W-1:0]      o_kept_pos
);

    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int SUM_W = mrmf_pkg::TERM_W + CNT_W;
    localparam int CW    = mrmf_pkg::COORD_W;
    localparam int HW    = mrmf_pkg::HALF_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_scan,  n_scan;
    logic [CNT_W-1:0] r_vidx,  n_vidx;
    logic             r_skip,  n_skip;
    logic             r_kept_valid, n_kept_valid;

    logic [mrmf_pkg::WORD_W-1:0] r_key;
    logic [mrmf_pkg::WORD_W-1:0] r_pos;
    logic signed [CW-1:0]        r_win_s;
    logic signed [CW-1:0]        r_win_e;
    logic [HW-1:0]               r_half;

    logic                        accept;
    logic                        wr_en;
    logic [IDX_W-1:0]            rd_addr;
    logic                        in_range;
    logic                        acc_clr;
    logic                        term_load;
    logic                        keep;
    logic [mrmf_pkg::SPAN_W-1:0] span;
    logic [mrmf_pkg::POS_W-1:0]  mz_end;
    mrmf_pkg::t_entry            wr_data;
    mrmf_pkg::t_entry            rd_data;
    mrmf_pkg::t_flags            flags;

    assign accept   = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign span     = i_mz_key[mrmf_pkg::SPAN_W-1:0] & mrmf_pkg::SPAN_MASK;
    assign mz_end   = i_mz_pos[mrmf_pkg::POS_W:1];
    assign in_range = (r_vidx < r_count);

    assign wr_data.iv_start = i_interval_start;
    assign wr_data.iv_end   = i_interval_end;

    // Sequencer: walk the store one entry per cycle
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_scan       = r_scan;
        n_vidx       = r_vidx;
        n_skip       = r_skip;
        n_kept_valid = 1'b0;
        wr_en        = 1'b0;
        acc_clr      = 1'b0;
        term_load    = 1'b0;
        rd_addr      = r_vidx[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                rd_addr = r_scan[IDX_W-1:0];
                if (accept) begin
                    case (i_kind)
                        mrmf_pkg::KIND_CLEAR: begin
                            n_count = '0;
                            n_scan  = '0;
                        end
                        mrmf_pkg::KIND_LOAD: begin
                            if (r_count < CNT_MAX) begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        mrmf_pkg::KIND_MZ: begin
                            acc_clr = 1'b1;
                            n_vidx  = r_scan;
                            n_skip  = 1'b1;
                            n_state = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_skip && in_range && flags.end_le_s) begin
                    // advance past an interval that ends before the window
                    n_scan  = r_scan + 1'b1;
                    n_vidx  = r_vidx + 1'b1;
                    rd_addr = n_vidx[IDX_W-1:0];
                end else if (in_range && flags.start_lt_e) begin
                    // add this interval and fetch the next one
                    term_load = 1'b1;
                    n_skip    = 1'b0;
                    n_vidx    = r_vidx + 1'b1;
                    rd_addr   = n_vidx[IDX_W-1:0];
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_kept_valid = keep;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_scan       <= '0;
            r_vidx       <= '0;
            r_skip       <= 1'b0;
            r_kept_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_scan       <= n_scan;
            r_vidx       <= n_vidx;
            r_skip       <= n_skip;
            r_kept_valid <= n_kept_valid;
        end
    end

    // Capture the minimizer word and its window
    always_ff @(posedge i_clk) begin
        if (accept && (i_kind == mrmf_pkg::KIND_MZ)) begin
            r_key   <= i_mz_key;
            r_pos   <= i_mz_pos;
            r_win_s <= $signed({2'b00, mz_end}) - $signed({{(CW-8){1'b0}}, span})
                       + $signed(CW'(1));
            r_win_e <= $signed({2'b00, mz_end}) + $signed(CW'(1));
            r_half  <= span[mrmf_pkg::SPAN_W-1:1];
        end
    end

    mrmf_store #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .IDX_W         (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mrmf_ovl_unit #(
        .SUM_W (SUM_W)
    ) u_ovl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (rd_data),
        .i_win_s     (r_win_s),
        .i_win_e     (r_win_e),
        .i_half      (r_half),
        .i_clr       (acc_clr),
        .i_term_load (term_load),
        .o_flags     (flags),
        .o_keep      (keep)
    );

    assign o_kept_valid = r_kept_valid;
    assign o_kept_key   = r_key;
    assign o_kept_pos   = r_pos;

endmodule

`default_nettype wire

// ===== hw/rtl/mrmf_store.sv =====
// ----------------------------------------------------------------------------
// mrmf_store
// Interval memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mrmf_store #(
    parameter int MAX_INTERVALS = mrmf_pkg::DEF_MAX_INTERVALS,
    parameter int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1
) (
    input  wire                  i_clk,
    input  wire                  i_wr_en,
    input  wire [IDX_W-1:0]      i_wr_addr,
    input  mrmf_pkg::t_entry     i_wr_data,
    input  wire [IDX_W-1:0]      i_rd_addr,
    output mrmf_pkg::t_entry     o_rd_data
);

    mrmf_pkg::t_entry r_mem [MAX_INTERVALS];
    mrmf_pkg::t_entry r_rd_data;

    // Write on load, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/mrmf_ovl_unit.sv =====
// ----------------------------------------------------------------------------
// mrmf_ovl_unit
// Shared compare and overlap unit with the masked length accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module mrmf_ovl_unit #(
    parameter int SUM_W = mrmf_pkg::TERM_W + 11
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  mrmf_pkg::t_entry                      i_entry,
    input  wire signed [mrmf_pkg::COORD_W-1:0]    i_win_s,
    input  wire signed [mrmf_pkg::COORD_W-1:0]    i_win_e,
    input  wire [mrmf_pkg::HALF_W-1:0]            i_half,
    input  wire                                   i_clr,
    input  wire                                   i_term_load,
    output mrmf_pkg::t_flags                      o_flags,
    output logic                                  o_keep
);

    localparam int CW = mrmf_pkg::COORD_W;
    localparam int TW = mrmf_pkg::TERM_W;

    logic signed [CW-1:0] st;
    logic signed [CW-1:0] en;
    logic signed [CW-1:0] ss;
    logic signed [CW-1:0] ee;
    logic signed [TW-1:0] term;

    logic signed [TW-1:0]    r_term;
    logic                    r_term_vld;
    logic signed [SUM_W-1:0] r_sum;

    // Compare the entry against the window and form the overlap term
    always_comb begin
        st = $signed({2'b00, i_entry.iv_start});
        en = $signed({2'b00, i_entry.iv_end});
        ss = (st > i_win_s) ? st : i_win_s;
        ee = (en < i_win_e) ? en : i_win_e;
        term = $signed({ee[CW-1], ee}) - $signed({ss[CW-1], ss});
        o_flags.end_le_s   = (en <= i_win_s);
        o_flags.start_lt_e = (st < i_win_e);
    end

    // Register the term, then add it into the running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_term_vld <= 1'b0;
            r_sum      <= '0;
        end else begin
            r_term_vld <= i_term_load;
            if (r_term_vld) begin
                r_sum <= r_sum + $signed({{(SUM_W-TW){r_term[TW-1]}}, r_term});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= term;
    end

    // Keep when the masked length is at most half the span
    assign o_keep = (r_sum <= $signed({{(SUM_W-mrmf_pkg::HALF_W){1'b0}}, i_half}));

endmodule

`default_nettype wire

// ===== hw/rtl/mrmf_checker.sv =====
// ----------------------------------------------------------------------------
// mrmf_checker
// Port-level checks of the filter's command timing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrmf_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         start,
    input wire                         busy,
    input wire [mrmf_pkg::KIND_W-1:0]  i_kind,
    input wire                         o_kept_valid
);

    // A kept word follows the end of a minimizer run
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_kept_valid |-> ($past(busy) && !busy))
        else $error("kept word without a preceding minimizer run");

    // A kept strobe is never held over consecutive cycles
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_kept_valid |=> !o_kept_valid)
        else $error("kept strobe held for more than one cycle");

    // Words other than minimizer words leave busy low and give no word
    a_short_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind != mrmf_pkg::KIND_MZ)) |=> (!busy && !o_kept_valid))
        else $error("clear or load word did not complete in one cycle");

    // A minimizer word starts a run
    a_mz_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == mrmf_pkg::KIND_MZ)) |=> busy)
        else $error("minimizer word did not raise busy");

endmodule

bind masked_region_minimizer_filter mrmf_checker u_mrmf_checker (.*);

`default_nettype wire

// ===== tb/mrmf_filter_checker.sv =====
// ----------------------------------------------------------------------------
// mrmf_filter_checker
// Watches the word and result channels of the masked region minimizer
// filter, keeps its own interval store and scan pointer, predicts which
// minimizers survive and compares every strobed result with the oldest
// prediction. Mismatches and unexpected results raise the failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mrmf_filter_checker #(
    parameter int MAX_INTERVALS = mrmf_pkg::DEF_MAX_INTERVALS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire                          i_busy,
    input  wire [mrmf_pkg::KIND_W-1:0]   i_kind,
    input  wire [mrmf_pkg::POS_W-1:0]    i_interval_start,
    input  wire [mrmf_pkg::POS_W-1:0]    i_interval_end,
    input  wire [mrmf_pkg::WORD_W-1:0]   i_mz_key,
    input  wire [mrmf_pkg::WORD_W-1:0]   i_mz_pos,
    input  wire                          i_kept_valid,
    input  wire [mrmf_pkg::WORD_W-1:0]   i_kept_key,
    input  wire [mrmf_pkg::WORD_W-1:0]   i_kept_pos,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_kept_count,
    output int                           o_dropped_count
);
    import mrmf_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] pos;
    } t_kept;

    t_entry      mask_store [MAX_INTERVALS];
    int unsigned mask_count;
    int unsigned scan_ptr;
    t_kept       kept_awaited [$];
    t_kept       kept_next;
    t_kept       kept_want;

    // Advance the scan pointer and sum the masked overlap of one minimizer
    function automatic bit minimizer_survives(input logic [WORD_W-1:0] key,
                                              input logic [WORD_W-1:0] pos);
        longint      p;
        longint      w;
        longint      s;
        longint      e;
        longint      iv_lo;
        longint      iv_hi;
        longint      masked;
        int unsigned v;
        bit          hit;
        p = longint'(pos[POS_W:1]);
        w = longint'(key[SPAN_W-1:0]);
        // window may start before position zero; longint keeps the sign
        s = p - (w - 1);
        e = s + w;
        while (scan_ptr < mask_count) begin
            iv_hi = longint'(mask_store[scan_ptr].iv_end);
            if (iv_hi > s) break;
            scan_ptr++;
        end
        masked = 0;
        hit = 1'b0;
        for (v = scan_ptr; v < mask_count; v++) begin
            iv_lo = longint'(mask_store[v].iv_start);
            iv_hi = longint'(mask_store[v].iv_end);
            if (iv_lo >= e) break;
            hit = 1'b1;
            // malformed intervals give zero or negative terms, summed as is
            masked += ((iv_hi < e) ? iv_hi : e) - ((iv_lo > s) ? iv_lo : s);
        end
        return !hit || (masked <= (w >>> 1));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mask_count = 0;
            scan_ptr   = 0;
            kept_awaited.delete();
        end else begin
            // take the accepted input word
            if (i_start && !i_busy) begin
                case (i_kind)
                    KIND_CLEAR: begin
                        mask_count = 0;
                        scan_ptr   = 0;
                    end
                    KIND_LOAD: begin
                        // drop loads once the store is full
                        if (mask_count < MAX_INTERVALS) begin
                            mask_store[mask_count].iv_start = i_interval_start;
                            mask_store[mask_count].iv_end   = i_interval_end;
                            mask_count++;
                        end
                    end
                    KIND_MZ: begin
                        if (minimizer_survives(i_mz_key, i_mz_pos)) begin
                            kept_next.key = i_mz_key;
                            kept_next.pos = i_mz_pos;
                            kept_awaited.push_back(kept_next);
                        end else begin
                            o_dropped_count++;
                        end
                    end
                    default: ;
                endcase
            end
            // match a strobed word (or an unknown strobe) against the oldest prediction
            if (i_kept_valid !== 1'b0) begin
                if (kept_awaited.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected kept word, expected none, got key %h pos %h",
                             $realtime, i_kept_key, i_kept_pos);
                end else begin
                    kept_want = kept_awaited.pop_front();
                    o_kept_count++;
                    if (i_kept_key !== kept_want.key) begin
                        o_fail_count++;
                        $display("%0t: kept key mismatch, expected %h, got %h",
                                 $realtime, kept_want.key, i_kept_key);
                    end
                    if (i_kept_pos !== kept_want.pos) begin
                        o_fail_count++;
                        $display("%0t: kept pos mismatch, expected %h, got %h",
                                 $realtime, kept_want.pos, i_kept_pos);
                    end
                end
            end
        end
        o_pending = kept_awaited.size();
    end

endmodule

// ===== tb/tb_masked_region_minimizer_filter.sv =====
// ----------------------------------------------------------------------------
// tb_masked_region_minimizer_filter
// Drives clear, load and minimizer words into the masked region minimizer
// filter: a directed pass over window edges, half-masked ties, malformed
// intervals and the last position, a store filled past capacity, then random
// sequences of sorted intervals and rising minimizers mixed with noise. The
// checker beside the block predicts the kept words; this module gives the
// verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_masked_region_minimizer_filter;
    import mrmf_pkg::*;

    localparam int                MAX_IV       = DEF_MAX_INTERVALS;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
    localparam int                RANDOM_WORDS = 1950;
    localparam int                MAX_WORD_GAP = 11;
    // a minimizer walks at most one store length of skips plus overlaps
    localparam int                DRAIN_CYCLES = 3 + 2 * MAX_IV + 50;
    localparam int                CYCLE_LIMIT  = 1000000;
    localparam logic [POS_W-1:0]  POS_MAX      = '1;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [KIND_W-1:0] i_kind;
    logic [POS_W-1:0]  i_interval_start;
    logic [POS_W-1:0]  i_interval_end;
    logic [WORD_W-1:0] i_mz_key;
    logic [WORD_W-1:0] i_mz_pos;
    logic              o_kept_valid;
    logic [WORD_W-1:0] o_kept_key;
    logic [WORD_W-1:0] o_kept_pos;

    int fail_count;
    int pending;
    int kept_count;
    int dropped_count;

    int clear_words;
    int load_words;
    int mz_words;
    int unused_words;
    int cycle_count;
    int random_mark;
    bit no_idle;
    bit tidy;

    masked_region_minimizer_filter #(
        .MAX_INTERVALS(MAX_IV)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_interval_start (i_interval_start),
        .i_interval_end   (i_interval_end),
        .i_mz_key         (i_mz_key),
        .i_mz_pos         (i_mz_pos),
        .o_kept_valid     (o_kept_valid),
        .o_kept_key       (o_kept_key),
        .o_kept_pos       (o_kept_pos)
    );

    mrmf_filter_checker #(
        .MAX_INTERVALS(MAX_IV)
    ) u_filter_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_kind           (i_kind),
        .i_interval_start (i_interval_start),
        .i_interval_end   (i_interval_end),
        .i_mz_key         (i_mz_key),
        .i_mz_pos         (i_mz_pos),
        .i_kept_valid     (o_kept_valid),
        .i_kept_key       (o_kept_key),
        .i_kept_pos       (o_kept_pos),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_kept_count     (kept_count),
        .o_dropped_count  (dropped_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // End the run at a generous cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Idle a random number of cycles, then hold one word until it is taken
    task automatic send_word(input logic [KIND_W-1:0] kind,
                             input logic [POS_W-1:0]  iv_lo,
                             input logic [POS_W-1:0]  iv_hi,
                             input logic [WORD_W-1:0] key,
                             input logic [WORD_W-1:0] pos);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WORD_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start            <= 1'b1;
        i_kind           <= kind;
        i_interval_start <= iv_lo;
        i_interval_end   <= iv_hi;
        i_mz_key         <= key;
        i_mz_pos         <= pos;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        case (kind)
            KIND_CLEAR: clear_words++;
            KIND_LOAD:  load_words++;
            KIND_MZ:    mz_words++;
            default:    unused_words++;
        endcase
    endtask

    task automatic clear_store();
        send_word(KIND_CLEAR, POS_W'($urandom), POS_W'($urandom), rand_word(), rand_word());
    endtask

    task automatic load_interval(input logic [POS_W-1:0] iv_lo,
                                 input logic [POS_W-1:0] iv_hi);
        send_word(KIND_LOAD, iv_lo, iv_hi, rand_word(), rand_word());
    endtask

    // Random upper key bits and strand around the given span and end position
    task automatic send_minimizer(input logic [SPAN_W-1:0] span,
                                  input logic [POS_W-1:0]  end_pos);
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] pos;
        key = rand_word();
        key[SPAN_W-1:0] = span;
        pos = rand_word();
        pos[POS_W:1] = end_pos;
        send_word(KIND_MZ, POS_W'($urandom), POS_W'($urandom), key, pos);
    endtask

    // Hold start low until every predicted kept word has come back
    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // One sequence: clear, sorted intervals, rising minimizers; untidy ones may
    // skip the clear and add malformed intervals, late loads, stray kinds and stray positions
    task automatic run_sequence(input int n_iv, input int n_mz, input bit neat);
        int unsigned base;
        int unsigned cursor;
        int unsigned p_floor;
        int unsigned p_cur;
        int unsigned step_max;
        int unsigned max_gap;
        int unsigned max_len;
        int unsigned lo;
        int unsigned hi;
        int unsigned span_sel;
        logic [SPAN_W-1:0] span;
        int i;
        base    = $urandom_range(0, 32'h7FFC_0000);
        max_gap = $urandom_range(0, 60);
        max_len = $urandom_range(1, 80);
        cursor  = base;
        if (neat || $urandom_range(0, 3) != 0) clear_store();
        for (i = 0; i < n_iv; i++) begin
            lo = cursor + $urandom_range(0, max_gap);
            hi = lo + $urandom_range(1, max_len);
            cursor = hi;
            if (!neat && $urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 2))
                    0: hi = lo - $urandom_range(0, (lo < 50) ? lo : 50);
                    1: begin
                        lo = $urandom;
                        hi = $urandom;
                    end
                    default: begin
                        lo = $urandom_range(base, lo);
                        hi = lo + $urandom_range(0, max_len);
                    end
                endcase
            end
            load_interval(POS_W'(lo), POS_W'(hi));
        end
        p_floor  = (base > 300) ? base - 300 : 0;
        p_cur    = p_floor;
        step_max = 2 * (cursor - base + 600) / (n_mz + 1) + 1;
        for (i = 0; i < n_mz; i++) begin
            span_sel = $urandom_range(0, 3);
            if (span_sel == 0) span = SPAN_W'($urandom_range(0, 15));
            else if (span_sel == 1) span = SPAN_W'($urandom_range(200, 255));
            else span = SPAN_W'($urandom_range(0, 255));
            p_cur += $urandom_range(0, step_max);
            if (!neat && $urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: send_word(KIND_UNUSED, POS_W'($urandom), POS_W'($urandom),
                                 rand_word(), rand_word());
                    1: begin
                        load_interval(POS_W'(cursor + 5),
                                      POS_W'(cursor + 5 + $urandom_range(0, max_len)));
                        cursor += 5 + max_len;
                    end
                    2: send_minimizer(span, POS_W'($urandom_range(p_floor, p_cur)));
                    default: send_minimizer(span, POS_W'($urandom));
                endcase
            end else begin
                send_minimizer(span, POS_W'(p_cur));
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_kind           = KIND_CLEAR;
        i_interval_start = '0;
        i_interval_end   = '0;
        i_mz_key         = '0;
        i_mz_pos         = '0;
        no_idle          = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty store: a window reaching below position zero is kept
        clear_store();
        send_word(KIND_MZ, '0, '0, '1, '0);
        load_interval(100, 200);
        load_interval(300, 310);
        load_interval(POS_MAX - 9, POS_MAX);
        // exactly half masked is kept, one more base drops it
        send_minimizer(20, 109);
        send_minimizer(20, 110);
        send_minimizer(23, 110);
        // zero span, two overlapped intervals, skip past the first interval
        send_minimizer(0, 150);
        send_minimizer(255, 400);
        send_minimizer(10, 305);
        // behind the scan pointer the first interval is no longer seen
        send_minimizer(20, 150);
        // last position with every key and position bit set
        send_word(KIND_MZ, '0, '0, '1, '1);
        send_word(KIND_UNUSED, POS_MAX, POS_MAX, '1, '1);
        // malformed intervals: reversed, out of order, then the whole range
        clear_store();
        load_interval(500, 400);
        load_interval(50, 60);
        send_minimizer(255, 600);
        load_interval(0, POS_MAX);
        send_minimizer(255, 1000);
        send_minimizer(1, 1000);
        // early minimizer against an interval at position zero
        clear_store();
        load_interval(0, 4);
        send_minimizer(200, 3);
        send_minimizer(8, 5);
        wait_drained();

        // fill the store past capacity, then random sequences
        random_mark = clear_words + load_words + mz_words;
        run_sequence(MAX_IV + 6, 160, 1'b1);
        while (clear_words + load_words + mz_words < random_mark + RANDOM_WORDS) begin
            tidy    = ($urandom_range(0, 3) != 0);
            no_idle = ($urandom_range(0, 4) == 0);
            run_sequence($urandom_range(0, 14), $urandom_range(1, 24), tidy);
            if ($urandom_range(0, 11) == 0) wait_drained();
        end

        // let the last word drain, then give a dropped one time to finish
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Sent %0d clear, %0d load, %0d minimizer and %0d unused-kind words,",
                 clear_words, load_words, mz_words, unused_words);
        $display("store overfilled once; %0d minimizers kept, %0d dropped, %0d mismatches.",
                 kept_count, dropped_count, fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
